[rtl/srp_pkg.sv]
// Shared types and constants for the sigmoid step-rate profile unit.
// No dependencies; used by the top level.
package srp_pkg;

    localparam int MAX_STEPS_DEF       = 4096;
    localparam int SIGMOID_ENTRIES_DEF = 1024;

    localparam logic [19:0] PERIOD_NUM = 20'd1000000;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FREQ_MAX  = 3'd0,
        REG_FREQ_MIN  = 3'd1,
        REG_STEEPNESS = 3'd2,
        REG_LENGTH    = 3'd3
    } cfg_reg_t;

    localparam logic [15:0] FREQ_MAX_RST  = 16'd40000;
    localparam logic [15:0] FREQ_MIN_RST  = 16'd500;
    localparam logic [7:0]  STEEP_RST     = 8'd80;
    localparam logic [12:0] LENGTH_RST    = 13'd1000;

    // Side information carried through the z divider
    typedef struct packed {
        logic neg;
        logic mode;
        logic last;
        logic oor;
    } zinfo_t;

    // Side information carried through the period divider
    typedef struct packed {
        logic [15:0] freq;
        logic        last;
        logic        oor;
    } pinfo_t;

endpackage

[rtl/srp_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with saturation flag.
// Stand-alone; side information of type SB_T travels with each item.
module srp_div #(
    parameter int  NW   = 28,
    parameter int  DW   = 13,
    parameter int  QW   = 15,
    parameter type SB_T = logic
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_take,
    input  logic [NW-1:0] in_num,
    input  logic [DW-1:0] in_den,
    input  SB_T           in_sb,
    output logic          out_valid,
    input  logic          out_take,
    output logic [QW-1:0] out_quo,
    output logic          out_sat,
    output SB_T           out_sb
);

    localparam int CW = ((NW > DW + QW) ? NW : DW + QW) + 1;

    logic [QW-1:0] v_reg;
    logic [CW-1:0] rem_reg [QW];
    logic [DW-1:0] den_reg [QW];
    logic [QW-1:0] quo_reg [QW];
    logic [QW-1:0] sat_reg;
    SB_T           sb_reg  [QW];
    logic [QW:0]   take;

    assign take[QW] = out_take;

    for (genvar t = 0; t < QW; t++) begin : g_st
        localparam int POS = QW - 1 - t;
        logic [CW-1:0] r_in;
        logic [CW-1:0] dsh;
        logic [DW-1:0] d_in;
        logic [QW-1:0] q_in;
        logic          s_in;
        logic          vin;
        SB_T           b_in;

        if (t == 0) begin : g_first
            assign r_in = CW'(in_num);
            assign d_in = in_den;
            assign q_in = '0;
            // quotient would not fit in QW bits
            assign s_in = CW'(in_num) >= (CW'(in_den) << QW);
            assign b_in = in_sb;
            assign vin  = in_valid;
        end else begin : g_next
            assign r_in = rem_reg[t-1];
            assign d_in = den_reg[t-1];
            assign q_in = quo_reg[t-1];
            assign s_in = sat_reg[t-1];
            assign b_in = sb_reg[t-1];
            assign vin  = v_reg[t-1];
        end

        assign dsh     = CW'(d_in) << POS;
        assign take[t] = !v_reg[t] || take[t+1];

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[t] <= 1'b0;
            end else if (take[t]) begin
                v_reg[t] <= vin;
            end
        end

        always_ff @(posedge aclk) begin
            if (take[t]) begin
                if (r_in >= dsh) begin
                    rem_reg[t] <= r_in - dsh;
                    quo_reg[t] <= q_in | (QW'(1) << POS);
                end else begin
                    rem_reg[t] <= r_in;
                    quo_reg[t] <= q_in;
                end
                den_reg[t] <= d_in;
                sat_reg[t] <= s_in;
                sb_reg[t]  <= b_in;
            end
        end
    end

    assign in_take   = take[0];
    assign out_valid = v_reg[QW-1];
    assign out_quo   = quo_reg[QW-1];
    assign out_sat   = sat_reg[QW-1];
    assign out_sb    = sb_reg[QW-1];

endmodule

[rtl/sigmoid_step_rate_profile_unit.sv]
// Sigmoid S-curve step-rate profile: frequency and timer period per ramp step.
// Depends on srp_pkg and srp_div.
//
// Fully pipelined: one item may enter every clock cycle, and each item passes
// the register stages of the datapath and the two bit-per-stage dividers
// (z scaling by the ramp length, then 1000000 over the frequency). Every stage
// holds its item under back-pressure, so the unit keeps taking items until all
// stages are full. The sigmoid table is a constant ROM built at elaboration and
// read in a registered stage. Write configuration only while no items are in
// flight.
module sigmoid_step_rate_profile_unit
    import srp_pkg::*;
#(
    parameter int MAX_STEPS       = MAX_STEPS_DEF,
    parameter int SIGMOID_ENTRIES = SIGMOID_ENTRIES_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]          cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [11:0]          s_step_index,
    input  logic                 s_mode,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [15:0]          m_freq_hz,
    output logic [15:0]          m_period_us,
    output logic                 m_last_step,
    output logic                 m_out_of_range
);

    localparam int JW = $clog2(SIGMOID_ENTRIES);
    localparam int PW = 15 + $clog2(SIGMOID_ENTRIES + 1);

    typedef logic [15:0] rom_arr_t [SIGMOID_ENTRIES+1];

    function automatic logic [15:0] rom_entry(input longint unsigned j);
        longint unsigned y;
        longint unsigned term;
        longint          sum;
        longint unsigned e;
        longint unsigned den;
        longint unsigned numr;
        longint unsigned q;
        longint unsigned r;
        y    = (j << 27) / SIGMOID_ENTRIES;
        term = 64'd1 << 31;
        sum  = 64'sd1 <<< 31;
        term = (term * y) >> 31;
        sum  = sum - longint'(term);
        term = ((term * y) >> 31) / 2;
        sum  = sum + longint'(term);
        term = ((term * y) >> 31) / 3;
        sum  = sum - longint'(term);
        term = ((term * y) >> 31) / 4;
        sum  = sum + longint'(term);
        term = ((term * y) >> 31) / 5;
        sum  = sum - longint'(term);
        e = (sum < 0) ? 64'd0 : longint'(sum);
        for (int n = 0; n < 8; n++) begin
            e = (e * e + (64'd1 << 30)) >> 31;
        end
        den  = (64'd1 << 31) + e;
        numr = (64'd1 << 47) + (den >> 1);
        q = 0;
        r = 0;
        for (int b = 47; b >= 0; b--) begin
            r = (r << 1) | ((numr >> b) & 64'd1);
            if (r >= den) begin
                r = r - den;
                q = q | (64'd1 << b);
            end
        end
        if (q > 64'd65535) begin
            q = 64'd65535;
        end
        return q[15:0];
    endfunction

    function automatic rom_arr_t build_rom();
        rom_arr_t rom;
        for (int j = 0; j <= SIGMOID_ENTRIES; j++) begin
            rom[j] = rom_entry(longint'(j));
        end
        return rom;
    endfunction

    localparam rom_arr_t SIG_ROM = build_rom();

    // ---------------- configuration registers
    logic [15:0] freq_max_reg;
    logic [15:0] freq_min_reg;
    logic [7:0]  steep_reg;
    logic [12:0] length_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            freq_max_reg <= FREQ_MAX_RST;
            freq_min_reg <= FREQ_MIN_RST;
            steep_reg    <= STEEP_RST;
            length_reg   <= LENGTH_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_FREQ_MAX:  freq_max_reg <= cfg_wdata;
                REG_FREQ_MIN:  freq_min_reg <= cfg_wdata;
                REG_STEEPNESS: steep_reg    <= cfg_wdata[7:0];
                REG_LENGTH:    length_reg   <= cfg_wdata[12:0];
                default: ;
            endcase
        end
    end

    // clamped ramp length
    logic [12:0] len;
    always_comb begin
        len = length_reg;
        if (32'(length_reg) > MAX_STEPS) begin
            len = 13'(MAX_STEPS);
        end
        if (len < 13'd2) begin
            len = 13'd2;
        end
    end

    // signed span, magnitude used in the scaling stage
    logic signed [16:0] delt;
    logic [15:0]        delt_abs;
    assign delt     = $signed({1'b0, freq_max_reg}) - $signed({1'b0, freq_min_reg});
    assign delt_abs = delt[16] ? 16'(-delt) : delt[15:0];

    // ---------------- stage control
    logic v0_reg, v1_reg, va_reg, vb_reg, vc_reg, vd_reg, ve_reg, vf_reg;
    logic take0, take1, takea, takeb, takec, taked, takee, takef;
    logic d1_take, d1_valid, d2_take;

    assign takef   = !vf_reg || d2_take;
    assign takee   = !ve_reg || takef;
    assign taked   = !vd_reg || takee;
    assign takec   = !vc_reg || taked;
    assign takeb   = !vb_reg || takec;
    assign takea   = !va_reg || takeb;
    assign take1   = !v1_reg || d1_take;
    assign take0   = !v0_reg || take1;
    assign s_ready = take0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
        end else begin
            if (take0) v0_reg <= s_valid;
            if (take1) v1_reg <= v0_reg;
            if (takea) va_reg <= d1_valid;
            if (takeb) vb_reg <= va_reg;
            if (takec) vc_reg <= vb_reg;
            if (taked) vd_reg <= vc_reg;
            if (takee) ve_reg <= vd_reg;
            if (takef) vf_reg <= ve_reg;
        end
    end

    // ---------------- stage 0: index clamp and distance from centre
    logic [12:0] idx_in, idx_c;
    logic [13:0] idx2;
    logic        oor_c, neg_c;
    logic [13:0] dmag_c;

    always_comb begin
        idx_in = {1'b0, s_step_index};
        oor_c  = idx_in >= len;
        idx_c  = oor_c ? len - 13'd1 : idx_in;
        idx2   = {idx_c, 1'b0};
        neg_c  = idx2 < {1'b0, len};
        dmag_c = neg_c ? {1'b0, len} - idx2 : idx2 - {1'b0, len};
    end

    logic [12:0] dmag0_reg, len0_reg;
    zinfo_t      zi0_reg;

    always_ff @(posedge aclk) begin
        if (take0) begin
            dmag0_reg <= dmag_c[12:0];
            len0_reg  <= len;
            zi0_reg   <= '{neg: neg_c, mode: s_mode,
                           last: (idx_c == len - 13'd1), oor: oor_c};
        end
    end

    // ---------------- stage 1: numerator of z
    logic [27:0] num1_reg;
    logic [12:0] len1_reg;
    zinfo_t      zi1_reg;

    always_ff @(posedge aclk) begin
        if (take1) begin
            num1_reg <= (28'(dmag0_reg * steep_reg) << 7) + 28'(len0_reg >> 1);
            len1_reg <= len0_reg;
            zi1_reg  <= zi0_reg;
        end
    end

    // ---------------- z magnitude = numerator / length
    logic [14:0] zq;
    logic        zsat;
    zinfo_t      zi_d;

    srp_div #(
        .NW   (28),
        .DW   (13),
        .QW   (15),
        .SB_T (zinfo_t)
    ) u_zdiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v1_reg),
        .in_take   (d1_take),
        .in_num    (num1_reg),
        .in_den    (len1_reg),
        .in_sb     (zi1_reg),
        .out_valid (d1_valid),
        .out_take  (takea),
        .out_quo   (zq),
        .out_sat   (zsat),
        .out_sb    (zi_d)
    );

    // ---------------- stage A: table index and fraction
    logic [14:0]   zmag;
    logic [PW-1:0] pa;
    assign zmag = zsat ? 15'h7FFF : zq;
    assign pa   = PW'(zmag) * PW'(SIGMOID_ENTRIES);

    logic [JW-1:0] ja_reg;
    logic [14:0]   fra_reg;
    zinfo_t        zia_reg;

    always_ff @(posedge aclk) begin
        if (takea) begin
            ja_reg  <= pa[JW+14:15];
            fra_reg <= pa[14:0];
            zia_reg <= zi_d;
        end
    end

    // ---------------- stage B: registered ROM read
    logic [15:0] t0b_reg, t1b_reg;
    logic [14:0] frb_reg;
    zinfo_t      zib_reg;

    always_ff @(posedge aclk) begin
        if (takeb) begin
            t0b_reg <= SIG_ROM[ja_reg];
            t1b_reg <= SIG_ROM[(JW+1)'(ja_reg) + (JW+1)'(1)];
            frb_reg <= fra_reg;
            zib_reg <= zia_reg;
        end
    end

    // ---------------- stage C: interpolation product
    logic [31:0] prodc_reg;
    logic [15:0] t0c_reg;
    zinfo_t      zic_reg;

    always_ff @(posedge aclk) begin
        if (takec) begin
            prodc_reg <= 32'((t1b_reg - t0b_reg) * frb_reg) + 32'd16384;
            t0c_reg   <= t0b_reg;
            zic_reg   <= zib_reg;
        end
    end

    // ---------------- stage D: sigmoid value, mirrored for negative z
    logic [16:0] spos;
    assign spos = 17'(t0c_reg) + prodc_reg[31:15];

    logic [16:0] sd_reg;
    zinfo_t      zid_reg;

    always_ff @(posedge aclk) begin
        if (taked) begin
            sd_reg  <= zic_reg.neg ? 17'h10000 - spos : spos;
            zid_reg <= zic_reg;
        end
    end

    // ---------------- stage E: span times sigmoid
    logic [33:0] re_reg;
    zinfo_t      zie_reg;

    always_ff @(posedge aclk) begin
        if (takee) begin
            re_reg  <= 34'(delt_abs * sd_reg) + 34'd32768;
            zie_reg <= zid_reg;
        end
    end

    // ---------------- stage F: frequency with clamp
    logic signed [18:0] scaled, fsum;
    logic [15:0]        freq_c;

    always_comb begin
        scaled = delt[16] ? -$signed({1'b0, re_reg[33:16]}) : $signed({1'b0, re_reg[33:16]});
        if (zie_reg.mode) begin
            fsum = $signed({3'b0, freq_max_reg}) - scaled;
        end else begin
            fsum = $signed({3'b0, freq_min_reg}) + scaled;
        end
        if (fsum < 0) begin
            freq_c = 16'd0;
        end else if (fsum > 19'sd65535) begin
            freq_c = 16'hFFFF;
        end else begin
            freq_c = fsum[15:0];
        end
    end

    logic [15:0] freqf_reg;
    pinfo_t      pif_reg;

    always_ff @(posedge aclk) begin
        if (takef) begin
            freqf_reg <= freq_c;
            pif_reg   <= '{freq: freq_c, last: zie_reg.last, oor: zie_reg.oor};
        end
    end

    // ---------------- period = 1000000 / frequency; saturates for f below 16
    logic [15:0] pq;
    logic        psat;
    pinfo_t      pi_d;

    srp_div #(
        .NW   (20),
        .DW   (16),
        .QW   (16),
        .SB_T (pinfo_t)
    ) u_pdiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (vf_reg),
        .in_take   (d2_take),
        .in_num    (PERIOD_NUM),
        .in_den    (freqf_reg),
        .in_sb     (pif_reg),
        .out_valid (m_valid),
        .out_take  (m_ready),
        .out_quo   (pq),
        .out_sat   (psat),
        .out_sb    (pi_d)
    );

    assign m_freq_hz      = pi_d.freq;
    assign m_period_us    = psat ? 16'hFFFF : pq;
    assign m_last_step    = pi_d.last;
    assign m_out_of_range = pi_d.oor;

    // ---------------- checks
    a_oor_implies_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_out_of_range |-> m_last_step)
        else $error("out-of-range item without last_step");

    a_zero_freq_period: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_freq_hz == 16'd0) |-> (m_period_us == 16'hFFFF))
        else $error("zero frequency without saturated period");

    a_full_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input blocked while output not stalled");

    a_period_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_freq_hz >= 16'd16) |-> (m_period_us <= 16'd62500))
        else $error("period out of range for frequency");

endmodule

[tb/sv/srp_checker.sv]
// Checker for the sigmoid step-rate profile unit: predicts each result from the
// accepted items and compares it with the result channel. Depends on srp_pkg.
`timescale 1ns / 100ps
module srp_checker
    import srp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [11:0] s_step_index,
    input  logic        s_mode,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [15:0] m_freq_hz,
    input  logic [15:0] m_period_us,
    input  logic        m_last_step,
    input  logic        m_out_of_range,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [15:0] freq;
        logic [15:0] period;
        logic        last;
        logic        oor;
    } step_rate_t;

    localparam int NENT = SIGMOID_ENTRIES_DEF;

    logic [31:0] sig_tab [0:NENT];
    logic [15:0] fmax, fmin;
    logic [7:0]  steep;
    logic [12:0] plen;
    step_rate_t  rate_q[$];

    function automatic logic [31:0] sig_entry(longint unsigned j);
        longint unsigned y, term, e, s;
        longint sum;
        y = (j << 27) / NENT;
        term = 64'd1 << 31;
        sum = 64'sd1 << 31;
        for (int k = 1; k <= 5; k++) begin
            term = ((term * y) >> 31) / k;
            if (k % 2 == 1) sum -= longint'(term);
            else sum += longint'(term);
        end
        e = (sum < 0) ? 0 : longint'(sum);
        for (int n = 0; n < 8; n++) e = (e * e + (64'd1 << 30)) >> 31;
        s = ((64'd1 << 47) + (((64'd1 << 31) + e) >> 1)) / ((64'd1 << 31) + e);
        if (s > 65535) s = 65535;
        return s[31:0];
    endfunction

    function automatic step_rate_t predict_rate(logic [11:0] idx_in, logic mode);
        step_rate_t r;
        longint unsigned len, idx, dmag, zmag, p, j, fr, spos, s, mag, sc;
        longint delt, f;
        logic neg, oor;
        len = plen;
        idx = idx_in;
        oor = 1'b0;
        if (len < 2) len = 2;
        if (len > MAX_STEPS_DEF) len = MAX_STEPS_DEF;
        if (idx >= len) begin
            idx = len - 1;
            oor = 1'b1;
        end
        r.last = (idx == len - 1);
        r.oor = oor;
        neg = (2 * idx) < len;
        dmag = neg ? len - 2 * idx : 2 * idx - len;
        zmag = (dmag * steep * 128 + len / 2) / len;
        if (zmag > 32767) zmag = 32767;
        p = zmag * NENT;
        j = p >> 15;
        fr = p & 64'h7FFF;
        if (j >= NENT) begin
            j = NENT - 1;
            fr = 64'h7FFF;
        end
        spos = sig_tab[j] + (((sig_tab[j+1] - sig_tab[j]) * fr + 16384) >> 15);
        s = neg ? 65536 - spos : spos;
        delt = longint'(fmax) - longint'(fmin);
        mag = delt < 0 ? -delt : delt;
        sc = (mag * s + 32768) >> 16;
        f = mode ? longint'(fmax) - (delt < 0 ? -longint'(sc) : longint'(sc))
                 : longint'(fmin) + (delt < 0 ? -longint'(sc) : longint'(sc));
        if (f < 0) f = 0;
        if (f > 65535) f = 65535;
        r.freq = f[15:0];
        if (f == 0) r.period = 16'hFFFF;
        else r.period = (1000000 / f > 65535) ? 16'hFFFF : 16'(1000000 / f);
        return r;
    endfunction

    initial begin
        for (int j = 0; j <= NENT; j++) sig_tab[j] = sig_entry(j);
    end

    always @(posedge aclk) begin
        step_rate_t e;
        if (!aresetn) begin
            fmax <= FREQ_MAX_RST;
            fmin <= FREQ_MIN_RST;
            steep <= STEEP_RST;
            plen <= LENGTH_RST;
            fail_count <= 0;
            pending <= 0;
            rate_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_reg_t'(cfg_index))
                    REG_FREQ_MAX:  fmax <= cfg_wdata;
                    REG_FREQ_MIN:  fmin <= cfg_wdata;
                    REG_STEEPNESS: steep <= cfg_wdata[7:0];
                    REG_LENGTH:    plen <= cfg_wdata[12:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) rate_q.push_back(predict_rate(s_step_index, s_mode));
            if (m_valid && m_ready) begin
                if (rate_q.size() == 0) begin
                    $display("%0t: unexpected result freq %0d period %0d",
                             $time, m_freq_hz, m_period_us);
                    fail_count <= fail_count + 1;
                end else begin
                    e = rate_q.pop_front();
                    if (e != {m_freq_hz, m_period_us, m_last_step, m_out_of_range}) begin
                        $display("%0t: expected freq %0d period %0d last %0b oor %0b, got %0d %0d %0b %0b",
                                 $time, e.freq, e.period, e.last, e.oor,
                                 m_freq_hz, m_period_us, m_last_step, m_out_of_range);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= rate_q.size();
        end
    end

endmodule

[tb/sv/sigmoid_step_rate_profile_unit_tb.sv]
// Testbench top for the sigmoid step-rate profile unit: stimulus, configuration
// phases and verdict. Depends on srp_pkg, srp_checker and the unit itself.
`timescale 1ns / 100ps
module sigmoid_step_rate_profile_unit_tb;
    import srp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        aclk, aresetn;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_wdata;
    logic        s_valid, s_ready, s_mode;
    logic [11:0] s_step_index;
    logic        m_valid, m_ready;
    logic [15:0] m_freq_hz, m_period_us;
    logic        m_last_step, m_out_of_range;
    int          fail_count, pending;
    int          cycles = 0;
    bit          calm;      // no idling in the final stretch
    bit          hold_rx;   // long receiver hold-off
    logic [12:0] cur_len;

    sigmoid_step_rate_profile_unit i_dut (.*);

    srp_checker i_chk (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver: random stall bursts, one long hold-off on request
    initial begin
        int burst;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_rx) m_ready <= 1'b0;
            else if (!calm && $urandom_range(0, 5) == 0) begin
                burst = $urandom_range(1, 8);
                m_ready <= 1'b0;
                repeat (burst - 1) @(negedge aclk);
            end else m_ready <= 1'b1;
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        if (idx == REG_LENGTH) cur_len = val[12:0];
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic send_step(logic [11:0] idx, logic mode);
        if (!calm && $urandom_range(0, 6) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_step_index <= idx;
        s_mode <= mode;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (50) @(negedge aclk);
    endtask

    task automatic set_profile(logic [15:0] fx, logic [15:0] fn, logic [7:0] k,
                               logic [12:0] len);
        drain();
        write_reg(REG_FREQ_MAX, fx);
        write_reg(REG_FREQ_MIN, fn);
        write_reg(REG_STEEPNESS, {8'd0, k});
        write_reg(REG_LENGTH, {3'd0, len});
    endtask

    function automatic logic [11:0] pick_index();
        int l;
        l = (cur_len < 2) ? 2 : int'(cur_len);
        case ($urandom_range(0, 9))
            0: return 12'($urandom);
            1: return 12'(l - 1);
            2: return 12'd0;
            3: return 12'(l / 2);
            default: return 12'($urandom_range(0, l > 4096 ? 4095 : l - 1));
        endcase
    endfunction

    initial begin
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_step_index = '0;
        s_mode = 1'b0;
        aresetn = 1'b0;
        calm = 1'b0;
        hold_rx = 1'b0;
        cur_len = LENGTH_RST;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // directed: reset profile, extremes of index and both modes
        send_step(12'd0, 1'b0);    send_step(12'd0, 1'b1);
        send_step(12'd500, 1'b0);  send_step(12'd999, 1'b0);
        send_step(12'd999, 1'b1);  send_step(12'd1000, 1'b0);
        send_step(12'd4095, 1'b1); send_step(12'd2730, 1'b0);
        // short length clamp, zero steepness, inverted limits, zero freqs
        set_profile(16'd65535, 16'd1, 8'd255, 13'd0);
        send_step(12'd0, 1'b0); send_step(12'd1, 1'b1); send_step(12'd4095, 1'b0);
        set_profile(16'd100, 16'd9000, 8'd0, 13'd8191);
        send_step(12'd0, 1'b0); send_step(12'd4095, 1'b1); send_step(12'd2048, 1'b0);
        set_profile(16'd0, 16'd0, 8'd16, 13'd4096);
        send_step(12'd0, 1'b1); send_step(12'd4095, 1'b0);
        set_profile(16'd0, 16'd65535, 8'd255, 13'd2);
        send_step(12'd0, 1'b0); send_step(12'd1, 1'b0); send_step(12'd1, 1'b1);
        drain();
        write_reg(cfg_reg_t'(3'd7), 16'hFFFF);  // unknown index is ignored
        send_step(12'd0, 1'b1);

        // sender pauses until everything is back; then a long receiver hold-off
        drain();
        hold_rx = 1'b1;
        fork
            begin
                repeat (200) @(negedge aclk);
                hold_rx = 1'b0;
            end
            for (int n = 0; n < 60; n++) send_step(pick_index(), 1'($urandom));
        join

        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: set_profile(FREQ_MAX_RST, FREQ_MIN_RST, STEEP_RST, LENGTH_RST);
                1: set_profile(16'd65535, 16'd0, 8'd255, 13'd4096);
                2: set_profile(16'd1, 16'd65535, 8'd1, 13'd3);
                default: set_profile(16'($urandom), 16'($urandom), 8'($urandom),
                                     $urandom_range(0, 1) ? 13'($urandom_range(2, 300))
                                                          : 13'($urandom));
            endcase
            if (ph == 9) calm = 1'b1;
            for (int n = 0; n < 155; n++) send_step(pick_index(), 1'($urandom));
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
        if (fail_count == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end

endmodule

[filelist.f]
rtl/srp_pkg.sv
rtl/srp_div.sv
rtl/sigmoid_step_rate_profile_unit.sv
tb/sv/srp_checker.sv
tb/sv/sigmoid_step_rate_profile_unit_tb.sv
